// File: rtl/bbpe_pkg.sv
// types shared by the bicubic patch evaluator: request, result and pipeline control
// no dependencies
package bbpe_pkg;

  // widest parameter carried down the pipe, enough for one at the largest fraction width
  localparam int PARAM_W = 25;
  localparam int COORD_W = 32;
  localparam int IN_PARAM_W = 17;
  localparam int NUM_COORDS = 3;
  localparam int GRID_N = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic [1:0]            row;
    logic [1:0]            column;
    coord_t                coord_x;
    coord_t                coord_y;
    coord_t                coord_z;
    logic [IN_PARAM_W-1:0] param_u;
    logic [IN_PARAM_W-1:0] param_v;
  } request_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [PARAM_W-1:0] t_u;
    logic [PARAM_W-1:0] t_v;
  } ctl_t;

endpackage

// File: rtl/bbpe_store.sv
// control point grid, 4x4 points of x/y/z, cleared at reset, written by load requests
// depends on bbpe_pkg
module bbpe_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  bbpe_pkg::request_t request,
  output bbpe_pkg::coord_t   grid [3*16]
);
  import bbpe_pkg::*;

  // grid index is coord*16 + row*4 + column, so each coord/row forms a group of four lanes
  coord_t pts [3*16];
  logic [3:0] idx;

  assign idx = {request.row, request.column};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3*16; i++) begin
        pts[i] <= '0;
      end
    end else if (we) begin
      pts[{2'd0, idx}]  <= request.coord_x;
      pts[{2'd1, idx}]  <= request.coord_y;
      pts[{2'd2, idx}]  <= request.coord_z;
    end
  end

  always_comb begin
    for (int i = 0; i < 3*16; i++) begin
      grid[i] = pts[i];
    end
  end

endmodule

// File: rtl/bbpe_stage.sv
// one de casteljau level: registered lerp of each adjacent pair within every group
// depends on bbpe_pkg
module bbpe_stage #(
  parameter int FRAC_BITS = 16,
  parameter int GROUPS    = 12,
  parameter int N         = 4,
  parameter bit USE_V     = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  bbpe_pkg::ctl_t   ctl_in,
  input  bbpe_pkg::coord_t pts_in  [GROUPS*N],
  output bbpe_pkg::ctl_t   ctl_out,
  output bbpe_pkg::coord_t pts_out [GROUPS*(N-1)]
);
  import bbpe_pkg::*;

  logic [PARAM_W-1:0] t;
  coord_t lerp [GROUPS*(N-1)];

  assign t = USE_V ? ctl_in.t_v : ctl_in.t_u;

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    for (genvar k = 0; k < N-1; k++) begin : g_lane
      localparam int I = g*N + k;
      localparam int O = g*(N-1) + k;
      logic signed [COORD_W:0]         diff;
      logic signed [PARAM_W+COORD_W+1:0] prod;
      logic signed [PARAM_W+COORD_W+1:0] shifted;

      assign diff    = {pts_in[I+1][COORD_W-1], pts_in[I+1]}
                     - {pts_in[I][COORD_W-1], pts_in[I]};
      assign prod    = diff * $signed({1'b0, t});
      // arithmetic shift gives the floor, the sum stays between the endpoints
      assign shifted = prod >>> FRAC_BITS;
      assign lerp[O] = pts_in[I] + shifted[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (ctl_in.valid) begin
      ctl_out.t_u <= ctl_in.t_u;
      ctl_out.t_v <= ctl_in.t_v;
      for (int i = 0; i < GROUPS*(N-1); i++) begin
        pts_out[i] <= lerp[i];
      end
    end
  end

endmodule

// File: rtl/bicubic_bezier_patch_evaluator_core.sv
// Bicubic Bezier patch evaluator: a load request writes one control point, an evaluate
// request returns one surface point, marked by done for one cycle; the receiver cannot
// hold it off and must take it in that cycle. busy stays low: a request is taken every
// cycle, loads and evaluates mixed freely, and an evaluate sees every load accepted
// before it. The point is computed by the six de Casteljau levels (three along u, three
// along v), each one registered multiply stage.
// Depends on bbpe_pkg, bbpe_store, bbpe_stage.
module bicubic_bezier_patch_evaluator_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bbpe_pkg::request_t request,
  output logic               done,
  output bbpe_pkg::result_t  result
);
  import bbpe_pkg::*;

  localparam logic [PARAM_W-1:0] ONE = PARAM_W'(1) << FRAC_BITS;

  logic   take;
  logic   load_we;
  ctl_t   ctl0;
  ctl_t   ctl1, ctl2, ctl3, ctl4, ctl5, ctl6;
  coord_t grid [3*16];
  coord_t s1 [12*3];
  coord_t s2 [12*2];
  coord_t s3 [12*1];
  coord_t s4 [3*3];
  coord_t s5 [3*2];
  coord_t s6 [3*1];
  logic [PARAM_W-1:0] raw_u, raw_v;

  assign busy    = 1'b0;
  assign take    = start && !busy;
  assign load_we = take && (request.operation == OP_LOAD);

  assign raw_u = PARAM_W'(request.param_u);
  assign raw_v = PARAM_W'(request.param_v);

  // parameters above one saturate to one
  always_comb begin
    ctl0.valid = take && (request.operation == OP_EVAL);
    ctl0.t_u   = (raw_u > ONE) ? ONE : raw_u;
    ctl0.t_v   = (raw_v > ONE) ? ONE : raw_v;
  end

  bbpe_store u_store (
    .clk     (clk),
    .rst     (rst),
    .we      (load_we),
    .request (request),
    .grid    (grid)
  );

  // along u: twelve groups (coord, row) of four columns
  bbpe_stage #(.FRAC_BITS(FRAC_BITS), .GROUPS(12), .N(4), .USE_V(1'b0)) u_u1 (
    .clk(clk), .rst(rst), .ctl_in(ctl0), .pts_in(grid), .ctl_out(ctl1), .pts_out(s1)
  );
  bbpe_stage #(.FRAC_BITS(FRAC_BITS), .GROUPS(12), .N(3), .USE_V(1'b0)) u_u2 (
    .clk(clk), .rst(rst), .ctl_in(ctl1), .pts_in(s1), .ctl_out(ctl2), .pts_out(s2)
  );
  bbpe_stage #(.FRAC_BITS(FRAC_BITS), .GROUPS(12), .N(2), .USE_V(1'b0)) u_u3 (
    .clk(clk), .rst(rst), .ctl_in(ctl2), .pts_in(s2), .ctl_out(ctl3), .pts_out(s3)
  );

  // row results of one coord sit side by side, so they regroup as three groups of four
  bbpe_stage #(.FRAC_BITS(FRAC_BITS), .GROUPS(3), .N(4), .USE_V(1'b1)) u_v1 (
    .clk(clk), .rst(rst), .ctl_in(ctl3), .pts_in(s3), .ctl_out(ctl4), .pts_out(s4)
  );
  bbpe_stage #(.FRAC_BITS(FRAC_BITS), .GROUPS(3), .N(3), .USE_V(1'b1)) u_v2 (
    .clk(clk), .rst(rst), .ctl_in(ctl4), .pts_in(s4), .ctl_out(ctl5), .pts_out(s5)
  );
  bbpe_stage #(.FRAC_BITS(FRAC_BITS), .GROUPS(3), .N(2), .USE_V(1'b1)) u_v3 (
    .clk(clk), .rst(rst), .ctl_in(ctl5), .pts_in(s5), .ctl_out(ctl6), .pts_out(s6)
  );

  assign done           = ctl6.valid;
  assign result.point_x = s6[0];
  assign result.point_y = s6[1];
  assign result.point_z = s6[2];

endmodule

// File: dv/bbpe_checker.sv
// checker for the bicubic patch evaluator: keeps its own copy of the control-point grid,
// predicts each surface point at the evaluate request and compares it with the result port
// depends on bbpe_pkg
module bbpe_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  bbpe_pkg::request_t request,
  input  logic               done,
  input  bbpe_pkg::result_t  result,
  output int                 errors,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbpe_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  coord_t  grid_x [16];
  coord_t  grid_y [16];
  coord_t  grid_z [16];
  result_t expected_points [$];

  // arithmetic shift on a signed 64-bit product rounds towards minus infinity
  function automatic longint interp(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> FRAC_BITS);
  endfunction

  function automatic longint curve(longint p0, longint p1, longint p2, longint p3,
                                   longint t);
    longint q0, q1, q2, r0, r1;
    q0 = interp(p0, p1, t);
    q1 = interp(p1, p2, t);
    q2 = interp(p2, p3, t);
    r0 = interp(q0, q1, t);
    r1 = interp(q1, q2, t);
    return interp(r0, r1, t);
  endfunction

  // rows reduced along u first, then the four row points along v
  function automatic coord_t patch_point(input coord_t g [16], longint u, longint v);
    longint rows [4];
    for (int k = 0; k < 4; k++)
      rows[k] = curve(g[4*k], g[4*k+1], g[4*k+2], g[4*k+3], u);
    return coord_t'(curve(rows[0], rows[1], rows[2], rows[3], v));
  endfunction

  function automatic longint clamp_param(logic [IN_PARAM_W-1:0] raw);
    return (longint'(raw) > ONE) ? ONE : longint'(raw);
  endfunction

  always @(posedge clk) begin
    result_t want;
    longint  u, v;
    int      idx;
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        grid_x[i] = '0;
        grid_y[i] = '0;
        grid_z[i] = '0;
      end
      expected_points.delete();
    end else begin
      if (start && !busy) begin
        if (request.operation == OP_LOAD) begin
          idx = {request.row, request.column};
          grid_x[idx] = request.coord_x;
          grid_y[idx] = request.coord_y;
          grid_z[idx] = request.coord_z;
        end else begin
          u = clamp_param(request.param_u);
          v = clamp_param(request.param_v);
          want.point_x = patch_point(grid_x, u, v);
          want.point_y = patch_point(grid_y, u, v);
          want.point_z = patch_point(grid_z, u, v);
          expected_points = {expected_points, want};
        end
      end
      if (done) begin
        if (expected_points.size() == 0) begin
          $error("surface point with no evaluate request waiting: x %0d y %0d z %0d",
                 result.point_x, result.point_y, result.point_z);
          errors++;
        end else begin
          want = expected_points.pop_front();
          if (result.point_x !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, result.point_x);
            errors++;
          end
          if (result.point_y !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, result.point_y);
            errors++;
          end
          if (result.point_z !== want.point_z) begin
            $error("point_z: expected %0d, got %0d", want.point_z, result.point_z);
            errors++;
          end
        end
      end
    end
    outstanding = expected_points.size();
  end

endmodule

// File: dv/bicubic_bezier_patch_evaluator_core_tb.sv
// testbench top for the bicubic patch evaluator: drives load and evaluate requests in
// bursts and gives the verdict; checking is done by bbpe_checker
// depends on bbpe_pkg, bbpe_checker and the evaluator core
module bicubic_bezier_patch_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbpe_pkg::*;

  localparam int FRAC = 16;
  localparam int ONE = 1 << FRAC;
  localparam int RANDOM_REQUESTS = 850;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;
  int       errors;
  int       outstanding;

  bicubic_bezier_patch_evaluator_core #(.FRAC_BITS(FRAC)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  bbpe_checker #(.FRAC_BITS(FRAC)) patch_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // parameters are don't-care on a load, so fill them with noise
  function automatic request_t load_req(logic [1:0] row, logic [1:0] column,
                                        coord_t x, coord_t y, coord_t z);
    request_t r;
    r.operation = OP_LOAD;
    r.row       = row;
    r.column    = column;
    r.coord_x   = x;
    r.coord_y   = y;
    r.coord_z   = z;
    r.param_u   = IN_PARAM_W'($urandom);
    r.param_v   = IN_PARAM_W'($urandom);
    return r;
  endfunction

  // row, column and coordinates are don't-care on an evaluate
  function automatic request_t eval_req(logic [IN_PARAM_W-1:0] u, logic [IN_PARAM_W-1:0] v);
    request_t r;
    r.operation = OP_EVAL;
    r.row       = 2'($urandom);
    r.column    = 2'($urandom);
    r.coord_x   = coord_t'($urandom);
    r.coord_y   = coord_t'($urandom);
    r.coord_z   = coord_t'($urandom);
    r.param_u   = u;
    r.param_v   = v;
    return r;
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'(32'h8000_0000);
      1: return coord_t'(32'h7FFF_FFFF);
      2, 3: return coord_t'($urandom_range(0, 32'h000F_FFFF)) - coord_t'(32'h0008_0000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [IN_PARAM_W-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return IN_PARAM_W'(ONE);
      2: return IN_PARAM_W'($urandom_range(ONE + 1, 32'h1FFFF));
      default: return IN_PARAM_W'($urandom_range(0, ONE));
    endcase
  endfunction

  // called at a falling edge; busy only moves after rising edges, so it is steady here
  task automatic send_request(input request_t r);
    logic taken;
    start   <= 1'b1;
    request <= r;
    taken = 1'b0;
    while (!taken) begin
      taken = !busy;
      @(negedge clk);
    end
  endtask

  // start must already be low; bounded so a lost result cannot hang the run
  task automatic drain();
    int waited;
    for (waited = 0; outstanding != 0 && waited < 2000; waited++)
      @(negedge clk);
  endtask

  initial begin
    request_t r;
    int       sent;
    int       burst;
    int       mode;
    int       gap;
    logic     settle;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty grid, corner loads at the coordinate extremes, parameter edges
    send_request(eval_req('0, '0));
    send_request(load_req(2'd0, 2'd0, coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF),
                          coord_t'(-1)));
    send_request(load_req(2'd0, 2'd3, coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000),
                          coord_t'(0)));
    send_request(load_req(2'd3, 2'd0, coord_t'(32'h8000_0000), coord_t'(32'h8000_0000),
                          coord_t'(32'h7FFF_FFFF)));
    send_request(load_req(2'd3, 2'd3, coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF),
                          coord_t'(32'h8000_0000)));
    send_request(load_req(2'd1, 2'd2, coord_t'(-1), coord_t'(32'h0001_0000),
                          coord_t'(32'hFFFF_0000)));
    send_request(eval_req('0, '0));
    send_request(eval_req(IN_PARAM_W'(ONE), '0));
    send_request(eval_req('0, IN_PARAM_W'(ONE)));
    send_request(eval_req(IN_PARAM_W'(ONE), IN_PARAM_W'(ONE)));
    // parameters above one saturate
    send_request(eval_req(IN_PARAM_W'(32'h1FFFF), IN_PARAM_W'(ONE + 1)));
    send_request(eval_req(IN_PARAM_W'(ONE / 2), IN_PARAM_W'(ONE / 2)));
    send_request(eval_req(IN_PARAM_W'(1), IN_PARAM_W'(ONE - 1)));
    send_request(eval_req(IN_PARAM_W'(ONE - 1), IN_PARAM_W'(1)));
    start <= 1'b0;
    drain();

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      mode  = $urandom_range(0, 3);
      burst = (mode == 0) ? $urandom_range(20, 30) : $urandom_range(1, 30);
      for (int k = 0; k < burst; k++) begin
        // mode 0 refills the whole grid, then evaluates on it
        if (mode == 0 && k < 16)
          r = load_req(2'(k / 4), 2'(k % 4), pick_coord(), pick_coord(), pick_coord());
        else if (mode == 0 || $urandom_range(0, 1) == 1)
          r = eval_req(pick_param(), pick_param());
        else
          r = load_req(2'($urandom), 2'($urandom), pick_coord(), pick_coord(),
                       pick_coord());
        send_request(r);
        sent++;
      end
      gap    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      settle = ($urandom_range(0, 19) == 0);
      if (gap != 0 || settle) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
        if (settle)
          drain();
      end
    end
    start <= 1'b0;
    drain();
    repeat (12) @(negedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      if (outstanding != 0)
        $error("%0d surface points never arrived", outstanding);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
